>>> rtl/core/swms_pkg.sv
// shared constants, types and helpers for the window match score block
`timescale 1ns / 1ps
package swms_pkg;

    localparam int MAX_SIZE    = 16;
    localparam int MAX_WIDTH   = 64;
    localparam int TPL_DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int STRIP_DEPTH = MAX_WIDTH * MAX_SIZE;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 10;
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int SIZE_W   = 5;
    localparam int WIDTH_W  = 7;
    localparam int COL_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int OFF_W    = 6;
    localparam int TPL_AW   = $clog2(TPL_DEPTH);
    localparam int STRIP_AW = $clog2(STRIP_DEPTH);
    localparam int COST_W   = 2 * CHAN_W;
    localparam int TERM_W   = 18;
    localparam int SCORE_W  = 26;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam logic [TERM_W-1:0] PENALTY_SSD = TERM_W'(3 * 255 * 255);
    localparam logic [TERM_W-1:0] PENALTY_SAD = TERM_W'(3 * 255);
    localparam logic [SCORE_W-1:0] SCORE_MAX  = SCORE_W'(49939200);

    typedef enum logic [OP_W-1:0] {
        OP_TPL_WRITE   = 2'd0,
        OP_STRIP_WRITE = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE         = 2'd0,
        CFG_WIN_SIZE     = 2'd1,
        CFG_SEARCH_WIDTH = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    function automatic logic [COST_W-1:0] chan_cost(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b,
                                                    input logic sad);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        chan_cost = sad ? {{(COST_W-CHAN_W){1'b0}}, d} : COST_W'(d * d);
    endfunction

endpackage

>>> rtl/core/swms_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module swms_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/stereo_window_match_scores.sv
// top level: template and strip stores, score sequencer and accumulator
//
// input stream (s_): one request per item. op 0 writes a template pixel,
// op 1 a strip pixel, op 2 starts a score run, op 3 is dropped. writes
// are taken one per cycle whenever no score run is in progress.
// output stream (m_): one request per offset 0..search_width-1 of a run,
// tlast on the final offset. results leave through an output register,
// so a new item is taken while the last result of a run still waits.
// a run walks win_size*win_size template pixels per offset, one strip
// memory read per cycle; the channel costs are then registered, summed
// into the accumulator and handed to the output register. offsets are
// scored one at a time: the next offset starts only after that handoff.
// when the receiver stalls, the finished sum is held and the next offset
// starts only once the output register is free.
// configuration (cfg_) is to be written only while no run is active; the
// block does not check this. a run latches mode, window size and strip
// width at its start. reset sets state, valid flags and configuration;
// pixel stores are not cleared and must be written before they are scored.
`timescale 1ns / 1ps
module stereo_window_match_scores (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [swms_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [swms_pkg::CFG_DW-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op, index, red, green, blue
    input  logic [swms_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // offset, score
    output logic [swms_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    import swms_pkg::*;

    // input fields
    logic [OP_W-1:0]    in_op;
    logic [INDEX_W-1:0] in_index;
    logic [PIXEL_W-1:0] in_pixel;
    logic               in_fire;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_index = s_tdata[OP_W+INDEX_W-1:OP_W];
    assign in_pixel = {s_tdata[OP_W+INDEX_W+CHAN_W-1:OP_W+INDEX_W],
                       s_tdata[OP_W+INDEX_W+2*CHAN_W-1:OP_W+INDEX_W+CHAN_W],
                       s_tdata[OP_W+INDEX_W+3*CHAN_W-1:OP_W+INDEX_W+2*CHAN_W]};
    assign in_fire  = s_tvalid && s_tready;

    // configuration registers
    logic               mode_reg;
    logic [SIZE_W-1:0]  win_size_reg;
    logic [WIDTH_W-1:0] search_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= 1'b0;
            win_size_reg     <= SIZE_W'(8);
            search_width_reg <= WIDTH_W'(MAX_WIDTH);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MODE:         mode_reg         <= cfg_wdata[0];
                CFG_WIN_SIZE:     win_size_reg     <= cfg_wdata[SIZE_W-1:0];
                CFG_SEARCH_WIDTH: search_width_reg <= cfg_wdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped run settings
    logic [SIZE_W-1:0]  size_eff;
    logic [WIDTH_W-1:0] width_eff;

    always_comb begin
        if (win_size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (win_size_reg > SIZE_W'(MAX_SIZE)) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = win_size_reg;
        end
        if (search_width_reg == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (search_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = search_width_reg;
        end
    end

    // sequencer state
    state_t               state_reg, state_next;
    logic                 sad_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     row_reg;
    logic [TPL_AW-1:0]    tpl_addr_reg;
    logic [STRIP_AW-1:0]  srow_reg;

    // pipeline
    logic                 p1_valid_reg, p1_pen_reg, p1_last_reg;
    logic                 p2_valid_reg, p2_pen_reg, p2_last_reg;
    logic [COST_W-1:0]    cost_r_reg, cost_g_reg, cost_b_reg;
    logic [SCORE_W-1:0]   acc_reg;
    logic                 acc_done_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [OFF_W-1:0]     m_offset_reg;
    logic [SCORE_W-1:0]   m_score_reg;
    logic                 m_last_reg;

    // control decode
    logic                 start_run;
    logic                 issue;
    logic                 pen;
    logic                 col_last;
    logic                 step_last;
    logic                 out_free;
    logic                 emit;
    logic                 run_last;
    logic                 tpl_we;
    logic                 strip_we;
    logic [STRIP_AW-1:0]  strip_raddr;
    logic [PIXEL_W-1:0]   tpl_rdata;
    logic [PIXEL_W-1:0]   strip_rdata;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pen      = (WIDTH_W'(off_reg) + WIDTH_W'(col_reg)) >= width_reg;
    assign col_last = SIZE_W'(col_reg) == (size_reg - SIZE_W'(1));
    assign step_last = col_last && (SIZE_W'(row_reg) == (size_reg - SIZE_W'(1)));
    assign run_last = WIDTH_W'(off_reg) == (width_reg - WIDTH_W'(1));
    assign strip_raddr = STRIP_AW'(srow_reg + STRIP_AW'(col_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (op_t'(in_op) == OP_COMPUTE)) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (step_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (acc_done_reg && out_free) begin
                    state_next = run_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        start_run = 1'b0;
        issue     = 1'b0;
        emit      = 1'b0;
        tpl_we    = 1'b0;
        strip_we  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                start_run = in_fire && (op_t'(in_op) == OP_COMPUTE);
                tpl_we    = in_fire && (op_t'(in_op) == OP_TPL_WRITE)
                            && (in_index < INDEX_W'(TPL_DEPTH));
                strip_we  = in_fire && (op_t'(in_op) == OP_STRIP_WRITE)
                            && ({1'b0, in_index} < (INDEX_W+1)'(STRIP_DEPTH));
            end
            ST_ISSUE: begin
                issue = 1'b1;
            end
            ST_WAIT: begin
                emit = acc_done_reg && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // run counters
    always_ff @(posedge aclk) begin
        if (start_run) begin
            sad_reg      <= mode_reg;
            size_reg     <= size_eff;
            width_reg    <= width_eff;
            off_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            tpl_addr_reg <= '0;
            srow_reg     <= '0;
        end else if (issue) begin
            tpl_addr_reg <= tpl_addr_reg + TPL_AW'(1);
            if (col_last) begin
                col_reg  <= '0;
                row_reg  <= row_reg + COL_W'(1);
                srow_reg <= STRIP_AW'(srow_reg + STRIP_AW'(width_reg));
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end else if (emit && !run_last) begin
            off_reg      <= off_reg + OFF_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            tpl_addr_reg <= '0;
            srow_reg     <= STRIP_AW'(off_reg) + STRIP_AW'(1);
        end
    end

    // pixel stores
    swms_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (TPL_DEPTH)
    ) u_tpl_ram (
        .aclk  (aclk),
        .we    (tpl_we),
        .waddr (in_index[TPL_AW-1:0]),
        .wdata (in_pixel),
        .raddr (tpl_addr_reg),
        .rdata (tpl_rdata)
    );

    swms_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STRIP_DEPTH)
    ) u_strip_ram (
        .aclk  (aclk),
        .we    (strip_we),
        .waddr (in_index[STRIP_AW-1:0]),
        .wdata (in_pixel),
        .raddr (strip_raddr),
        .rdata (strip_rdata)
    );

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // channel costs
    always_ff @(posedge aclk) begin
        p1_pen_reg  <= pen;
        p1_last_reg <= step_last;
        p2_pen_reg  <= p1_pen_reg;
        p2_last_reg <= p1_last_reg;
        cost_r_reg  <= chan_cost(tpl_rdata[3*CHAN_W-1:2*CHAN_W],
                                 strip_rdata[3*CHAN_W-1:2*CHAN_W], sad_reg);
        cost_g_reg  <= chan_cost(tpl_rdata[2*CHAN_W-1:CHAN_W],
                                 strip_rdata[2*CHAN_W-1:CHAN_W], sad_reg);
        cost_b_reg  <= chan_cost(tpl_rdata[CHAN_W-1:0],
                                 strip_rdata[CHAN_W-1:0], sad_reg);
    end

    // accumulate
    logic [TERM_W-1:0] term;

    always_comb begin
        if (p2_pen_reg) begin
            term = sad_reg ? PENALTY_SAD : PENALTY_SSD;
        end else begin
            term = TERM_W'(cost_r_reg) + TERM_W'(cost_g_reg) + TERM_W'(cost_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_done_reg <= 1'b0;
        end else if (start_run || emit) begin
            acc_done_reg <= 1'b0;
        end else if (p2_valid_reg && p2_last_reg) begin
            acc_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_run || emit) begin
            acc_reg <= '0;
        end else if (p2_valid_reg) begin
            acc_reg <= acc_reg + SCORE_W'(term);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_offset_reg <= off_reg;
            m_score_reg  <= acc_reg;
            m_last_reg   <= run_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_score_reg, m_offset_reg};
    assign m_tlast  = m_last_reg;

    // checks
    a_pipe_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("score pipeline busy while idle");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_done_reg |-> (state_reg == ST_WAIT))
        else $error("finished sum outside wait state");

    a_score_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_score_reg <= SCORE_MAX))
        else $error("score above largest possible value");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> !$past(emit))
        else $error("result loaded over a waiting result");

endmodule
